/* src/svk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svk_pkg: shared types and constants for the linear elastic stress pipeline
// Word layouts, fixed point widths, register indexes and entry tables.
// ----------------------------------------------------------------------------
package svk_pkg;

    localparam int DIM_DEFAULT = 3;

    // matrix entries in, Q4.28
    localparam int MW = 32;
    // product of two entries, Q8.56
    localparam int PRW = 2 * MW;
    // strain held as integer X with E = X / 2^57
    localparam int XW  = 68;
    localparam int XLW = 34;
    localparam int XHW = XW - XLW;
    localparam int STRAIN_SH = 29;
    localparam int ONE_SH    = 56;

    // modulus operands (2*G is one bit wider than a register)
    localparam int LW  = 40;
    localparam int CW  = LW + 1;
    localparam int CLW = 21;
    localparam int CHW = CW - CLW;
    localparam int PW  = XLW + 1 + CLW + 1;

    // stress accumulator before rounding
    localparam int VW  = 110;
    localparam int RSH = 41;
    localparam int OW  = 64;

    localparam int NE  = 6;
    localparam int LAT = 8;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_LAMBDA = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SHEAR  = 2'd1;

    // result entry order: 00 11 22 01 02 12
    localparam int ROW [NE] = '{0, 1, 2, 0, 0, 1};
    localparam int COL [NE] = '{0, 1, 2, 1, 2, 2};

    localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< ONE_SH;
    localparam logic signed [VW-1:0] RND   = VW'(1) <<< (RSH - 1);
    localparam logic signed [OW-1:0] S_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] S_MIN = {1'b1, {(OW-1){1'b0}}};

    typedef struct packed {
        logic                 func;
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m20;
        logic signed [MW-1:0] m21;
        logic signed [MW-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] s00;
        logic signed [OW-1:0] s11;
        logic signed [OW-1:0] s22;
        logic signed [OW-1:0] s01;
        logic signed [OW-1:0] s02;
        logic signed [OW-1:0] s12;
        logic                 saturated;
    } t_out;

endpackage
`default_nettype wire

/* src/linear_elastic_pk2_stress.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// linear_elastic_pk2_stress: Saint Venant-Kirchhoff stress, one particle a word
// Green strain (or given strain), trace, scaled by the Lame constants,
// rounded to Q48.16 with saturation.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy is low whenever reset is released.
// Depth is set by the split 68x41 modulus multipliers (three stages).
// Reset clears the valid pipe and both modulus registers; no result is
// lost to stalls; the receiver must always take o_strobe words, which the block does not enforce.
module linear_elastic_pk2_stress #(
    parameter int DIMENSION = svk_pkg::DIM_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire svk_pkg::t_in                  i_item,
    output logic                               o_strobe,
    output svk_pkg::t_out                      o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [svk_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [svk_pkg::LW-1:0]        i_cfg_data
);

    logic                     w_acc;
    logic [svk_pkg::LAT-1:0]  r_vld;
    logic [svk_pkg::LW-1:0]   r_lambda, r_shear;

    logic signed [svk_pkg::MW-1:0]  w_m    [3][3];
    logic signed [svk_pkg::PRW-1:0] r_prod [svk_pkg::NE][3];
    logic signed [svk_pkg::MW-1:0]  r_mt   [svk_pkg::NE];
    logic                           r_func;

    logic signed [svk_pkg::XW-1:0]  n_x  [svk_pkg::NE];
    logic signed [svk_pkg::XW-1:0]  r_x2 [svk_pkg::NE];
    logic signed [svk_pkg::XW-1:0]  r_x3 [svk_pkg::NE];
    logic signed [svk_pkg::XW-1:0]  r_tr;

    logic        [svk_pkg::CW-1:0]  w_g2, w_lam;
    logic signed [svk_pkg::VW-1:0]  w_gx [svk_pkg::NE];
    logic signed [svk_pkg::VW-1:0]  w_ltr;
    logic signed [svk_pkg::VW-1:0]  n_v  [svk_pkg::NE];
    logic signed [svk_pkg::VW-1:0]  r_v  [svk_pkg::NE];

    logic signed [svk_pkg::OW-1:0]  n_s  [svk_pkg::NE];
    logic                           n_sat;
    svk_pkg::t_out                  r_out;

    assign busy        = ~i_rst_n;
    assign w_acc       = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // ---- control: valid pipe and modulus registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_lambda <= '0;
            r_shear  <= '0;
        end else begin
            r_vld <= {r_vld[svk_pkg::LAT-2:0], w_acc};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    svk_pkg::CFG_LAMBDA: r_lambda <= i_cfg_data;
                    svk_pkg::CFG_SHEAR:  r_shear  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        w_m[0][0] = i_item.m00; w_m[0][1] = i_item.m01; w_m[0][2] = i_item.m02;
        w_m[1][0] = i_item.m10; w_m[1][1] = i_item.m11; w_m[1][2] = i_item.m12;
        w_m[2][0] = i_item.m20; w_m[2][1] = i_item.m21; w_m[2][2] = i_item.m22;
    end

    // ---- stage 1: column dot product terms of F^T F
    always_ff @(posedge i_clk) begin
        r_func <= i_item.func;
        for (int e = 0; e < svk_pkg::NE; e++) begin
            r_mt[e] <= w_m[svk_pkg::ROW[e]][svk_pkg::COL[e]];
            for (int k = 0; k < 3; k++) begin
                r_prod[e][k] <= svk_pkg::PRW'(w_m[k][svk_pkg::ROW[e]])
                              * svk_pkg::PRW'(w_m[k][svk_pkg::COL[e]]);
            end
        end
    end

    // ---- stage 2: strain X in Q.57
    always_comb begin
        for (int e = 0; e < svk_pkg::NE; e++) begin
            if (svk_pkg::ROW[e] >= DIMENSION || svk_pkg::COL[e] >= DIMENSION) begin
                n_x[e] = '0;
            end else if (r_func) begin
                n_x[e] = svk_pkg::XW'(r_mt[e]) <<< svk_pkg::STRAIN_SH;
            end else begin
                n_x[e] = svk_pkg::XW'(r_prod[e][0]) + svk_pkg::XW'(r_prod[e][1])
                       + ((DIMENSION > 2) ? svk_pkg::XW'(r_prod[e][2]) : '0)
                       - ((svk_pkg::ROW[e] == svk_pkg::COL[e]) ? svk_pkg::ONE_X : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x2 <= n_x;
    end

    // ---- stage 3: trace
    always_ff @(posedge i_clk) begin
        r_x3 <= r_x2;
        r_tr <= r_x2[0] + r_x2[1] + r_x2[2];
    end

    // ---- stages 4..6: modulus products
    assign w_g2  = {r_shear, 1'b0};
    assign w_lam = {1'b0, r_lambda};

    for (genvar e = 0; e < svk_pkg::NE; e++) begin : g_gx
        svk_wmul u_gx (
            .i_clk (i_clk),
            .i_x   (r_x3[e]),
            .i_c   (w_g2),
            .o_p   (w_gx[e])
        );
    end

    svk_wmul u_ltr (
        .i_clk (i_clk),
        .i_x   (r_tr),
        .i_c   (w_lam),
        .o_p   (w_ltr)
    );

    // ---- stage 7: add volumetric term on the diagonal, round bias
    always_comb begin
        for (int e = 0; e < svk_pkg::NE; e++) begin
            if (svk_pkg::ROW[e] >= DIMENSION || svk_pkg::COL[e] >= DIMENSION) begin
                n_v[e] = '0;
            end else begin
                n_v[e] = w_gx[e] + svk_pkg::RND
                       + ((svk_pkg::ROW[e] == svk_pkg::COL[e]) ? w_ltr : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    // ---- stage 8: drop 41 fraction bits, clip to 64 bits
    always_comb begin
        n_sat = 1'b0;
        for (int e = 0; e < svk_pkg::NE; e++) begin
            if ((&r_v[e][svk_pkg::VW-1:svk_pkg::RSH+svk_pkg::OW-1]) ||
                !(|r_v[e][svk_pkg::VW-1:svk_pkg::RSH+svk_pkg::OW-1])) begin
                n_s[e] = r_v[e][svk_pkg::RSH+svk_pkg::OW-1:svk_pkg::RSH];
            end else begin
                n_s[e] = r_v[e][svk_pkg::VW-1] ? svk_pkg::S_MIN : svk_pkg::S_MAX;
                n_sat  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.s00       <= n_s[0];
        r_out.s11       <= n_s[1];
        r_out.s22       <= n_s[2];
        r_out.s01       <= n_s[3];
        r_out.s02       <= n_s[4];
        r_out.s12       <= n_s[5];
        r_out.saturated <= n_sat;
    end

    assign o_strobe = r_vld[svk_pkg::LAT-1];
    assign o_result = r_out;

endmodule
`default_nettype wire

/* src/svk_wmul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svk_wmul: three stage signed by unsigned wide multiplier
// Splits a 68-bit signed operand and a 41-bit unsigned operand into halves,
// registers the four partial products, folds them in two add stages.
// ----------------------------------------------------------------------------
module svk_wmul (
    input  wire logic                            i_clk,
    input  wire logic signed [svk_pkg::XW-1:0]   i_x,
    input  wire logic        [svk_pkg::CW-1:0]   i_c,
    output logic signed      [svk_pkg::VW-1:0]   o_p
);

    logic        [svk_pkg::XLW-1:0] w_xl;
    logic signed [svk_pkg::XHW-1:0] w_xh;
    logic        [svk_pkg::CLW-1:0] w_cl;
    logic        [svk_pkg::CHW-1:0] w_ch;

    logic signed [svk_pkg::PW-1:0] r_pll, r_plh, r_phl, r_phh;
    logic signed [svk_pkg::VW-1:0] r_lo, r_hi, r_p;

    assign w_xl = i_x[svk_pkg::XLW-1:0];
    assign w_xh = i_x[svk_pkg::XW-1:svk_pkg::XLW];
    assign w_cl = i_c[svk_pkg::CLW-1:0];
    assign w_ch = i_c[svk_pkg::CW-1:svk_pkg::CLW];

    always_ff @(posedge i_clk) begin
        r_pll <= svk_pkg::PW'($signed({1'b0, w_xl})) * svk_pkg::PW'($signed({1'b0, w_cl}));
        r_plh <= svk_pkg::PW'($signed({1'b0, w_xl})) * svk_pkg::PW'($signed({1'b0, w_ch}));
        r_phl <= svk_pkg::PW'(w_xh) * svk_pkg::PW'($signed({1'b0, w_cl}));
        r_phh <= svk_pkg::PW'(w_xh) * svk_pkg::PW'($signed({1'b0, w_ch}));

        r_lo <= svk_pkg::VW'(r_pll) + (svk_pkg::VW'(r_plh) <<< svk_pkg::CLW);
        r_hi <= svk_pkg::VW'(r_phl) + (svk_pkg::VW'(r_phh) <<< svk_pkg::CLW);

        r_p  <= r_lo + (r_hi <<< svk_pkg::XLW);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

/* src/svk_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svk_checker: port level checks for the stress pipeline
// Fixed latency in both directions, reset flush, saturation flag sanity.
// ----------------------------------------------------------------------------
module svk_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire svk_pkg::t_in                  i_item,
    input  wire logic                          o_strobe,
    input  wire svk_pkg::t_out                 o_result,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          o_cfg_ready,
    input  wire logic [svk_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [svk_pkg::LW-1:0]        i_cfg_data
);

    logic w_acc;
    logic w_ext;

    assign w_acc = start & ~busy;

    // a clipped word must show at least one entry pinned to a rail
    assign w_ext = (o_result.s00 == svk_pkg::S_MAX) || (o_result.s00 == svk_pkg::S_MIN)
                || (o_result.s11 == svk_pkg::S_MAX) || (o_result.s11 == svk_pkg::S_MIN)
                || (o_result.s22 == svk_pkg::S_MAX) || (o_result.s22 == svk_pkg::S_MIN)
                || (o_result.s01 == svk_pkg::S_MAX) || (o_result.s01 == svk_pkg::S_MIN)
                || (o_result.s02 == svk_pkg::S_MAX) || (o_result.s02 == svk_pkg::S_MIN)
                || (o_result.s12 == svk_pkg::S_MAX) || (o_result.s12 == svk_pkg::S_MIN);

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##(svk_pkg::LAT) o_strobe)
        else $error("accepted word did not come out after fixed latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, svk_pkg::LAT))
        else $error("result strobe without matching accepted word");

    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.saturated) |-> w_ext)
        else $error("saturated set but no entry at a rail");

endmodule

bind linear_elastic_pk2_stress svk_checker u_svk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_item      (i_item),
    .o_strobe    (o_strobe),
    .o_result    (o_result),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
`default_nettype wire
